@@ sv/mgfw_pkg.sv @@
// Shared constants and types of the full-weighting restriction unit.
package mgfw_pkg;

  localparam int MAX_COARSE_DEF  = 512;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 10;
  localparam int IDX_W           = 9;
  localparam int SIZE_MIN        = 3;
  localparam int FIFO_DEPTH      = 4;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] crow;
    logic [IDX_W-1:0] ccol;
  } tag_t;

  typedef struct packed {
    logic s1_vld;
    logic s2_vld;
  } pipe_stat_t;

endpackage

@@ sv/mgfw_line_mem.sv @@
// Pair of line buffers: one write port, one registered read port.
module mgfw_line_mem #(
  parameter int AW = 10,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata_up,
  input  logic [DW-1:0] wdata_mid,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_up,
  output logic [DW-1:0] rdata_mid
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] upper_mem [DEPTH];
  logic [DW-1:0] middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      upper_mem[waddr]  <= wdata_up;
      middle_mem[waddr] <= wdata_mid;
    end
    rdata_up  <= upper_mem[raddr];
    rdata_mid <= middle_mem[raddr];
  end

endmodule

@@ sv/mgfw_datapath.sv @@
// Window registers, line-buffer forwarding and the two-stage weighted sum.
module mgfw_datapath #(
  parameter int AW = 10,
  parameter int SW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic signed [SW-1:0]  x,
  input  logic [AW-1:0]         addr,
  input  mgfw_pkg::tag_t        tag,
  input  logic [SW-1:0]         rd_top,
  input  logic [SW-1:0]         rd_mid,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [SW-1:0]         wr_up,
  output logic [SW-1:0]         wr_mid,
  output logic                  push,
  output logic signed [SW+3:0]  push_value,
  output mgfw_pkg::tag_t        push_tag,
  output mgfw_pkg::pipe_stat_t  stat
);

  localparam int OW = SW + 4;

  logic                 s1_vld_r;
  logic signed [SW-1:0] s1_x_r;
  logic [AW-1:0]        s1_addr_r;
  mgfw_pkg::tag_t       s1_tag_r;
  logic                 fwd_r;
  logic [SW-1:0]        fwd_top_r;
  logic [SW-1:0]        fwd_mid_r;

  logic signed [SW-1:0] win_r [6];

  logic                 s2_vld_r;
  mgfw_pkg::tag_t       s2_tag_r;
  logic signed [OW-1:0] s2_p0_r;
  logic signed [OW-1:0] s2_p1_r;

  logic signed [SW-1:0] top_e;
  logic signed [SW-1:0] mid_e;
  logic signed [OW-1:0] w0_e, w1_e, w2_e, w3_e, w4_e, w5_e, top_x, mid_x, x_x;
  logic signed [OW-1:0] p0_nxt;
  logic signed [OW-1:0] p1_nxt;

  assign top_e = fwd_r ? $signed(fwd_top_r) : $signed(rd_top);
  assign mid_e = fwd_r ? $signed(fwd_mid_r) : $signed(rd_mid);

  assign w0_e  = OW'(win_r[0]);
  assign w1_e  = OW'(win_r[1]);
  assign w2_e  = OW'(win_r[2]);
  assign w3_e  = OW'(win_r[3]);
  assign w4_e  = OW'(win_r[4]);
  assign w5_e  = OW'(win_r[5]);
  assign top_x = OW'(top_e);
  assign mid_x = OW'(mid_e);
  assign x_x   = OW'(s1_x_r);

  // centre x4, edges x2, corners x1
  assign p0_nxt = (w3_e <<< 2) + ((w1_e + w2_e) <<< 1) + w0_e + w4_e;
  assign p1_nxt = ((mid_x + w5_e) <<< 1) + top_x + x_x;

  assign wr_en   = s1_vld_r;
  assign wr_addr = s1_addr_r;
  assign wr_up   = mid_e;
  assign wr_mid  = s1_x_r;

  assign push       = s2_vld_r && s2_tag_r.emit;
  assign push_value = s2_p0_r + s2_p1_r;
  assign push_tag   = s2_tag_r;

  assign stat.s1_vld = s1_vld_r;
  assign stat.s2_vld = s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r    <= x;
    s1_addr_r <= addr;
    s1_tag_r  <= tag;
    fwd_r     <= s1_vld_r && (s1_addr_r == addr);
    fwd_top_r <= mid_e;
    fwd_mid_r <= s1_x_r;
    s2_tag_r  <= s1_tag_r;
    s2_p0_r   <= p0_nxt;
    s2_p1_r   <= p1_nxt;
    if (s1_vld_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top_e;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_e;
      win_r[4] <= win_r[5];
      win_r[5] <= s1_x_r;
    end
  end

  a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r && $past(acc) |-> s1_vld_r)
    else $error("forward flagged without a word in stage 1");

endmodule

@@ sv/mgfw_out_fifo.sv @@
// Small result queue that decouples the sum pipeline from the output port.
module mgfw_out_fifo #(
  parameter int DW    = 39,
  parameter int DEPTH = mgfw_pkg::FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [DW-1:0]              push_data,
  input  logic                       pop_ready,
  output logic                       pop_valid,
  output logic [DW-1:0]              pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];
  assign count     = cnt_r;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CW'(DEPTH))
    else $error("result queue overflow");

endmodule

@@ sv/multigrid_full_weighting_restrict_unit.sv @@
// Top level of the 2-D full-weighting restriction unit.
//
//  channel | direction | words
//  in_     | sink      | fine_sample (Q8.8), grid_start
//  out_    | source    | coarse_value (Q8.12), coarse_row, coarse_col, last_of_grid
//  cfg_    | sink      | index 0 coarse_rows, index 1 coarse_cols (always ready)
//
//  One fine word per cycle while in_ready is high; the word that completes a
//  window goes through the line-buffer read, partial sums and final add.
//  After reset the line buffers are swept to zero, one entry a cycle, over all
//  2*MAX_COARSE entries; in_ready stays low during the sweep.
//  in_ready also drops when the 4-entry result queue could fill from words in flight.
module multigrid_full_weighting_restrict_unit #(
  parameter int MAX_COARSE  = mgfw_pkg::MAX_COARSE_DEF,
  parameter int SAMPLE_BITS = mgfw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_fine_sample,
  input  logic                          in_grid_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS+3:0] out_coarse_value,
  output logic [mgfw_pkg::IDX_W-1:0]    out_coarse_row,
  output logic [mgfw_pkg::IDX_W-1:0]    out_coarse_col,
  output logic                          out_last_of_grid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mgfw_pkg::cfg_reg_t            cfg_index,
  input  logic [mgfw_pkg::CFG_W-1:0]    cfg_data
);

  localparam int LINE_DEPTH = 2 * MAX_COARSE;
  localparam int CNT_W      = $clog2(LINE_DEPTH);
  localparam int SW         = SAMPLE_BITS;
  localparam int OW         = SAMPLE_BITS + 4;
  localparam int IW         = mgfw_pkg::IDX_W;
  localparam int CFW        = mgfw_pkg::CFG_W;
  localparam int CLW        = ((CFW > CNT_W) ? CFW : CNT_W) + 1;
  localparam int FD         = mgfw_pkg::FIFO_DEPTH;
  localparam int FCW        = $clog2(FD + 1);
  localparam int RES_W      = OW + 2 * IW + 1;

  logic [CNT_W-1:0] rows_r, cols_r;
  logic [CNT_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic             clr_busy_r;
  logic [CNT_W-1:0] clr_addr_r;

  logic [CNT_W-1:0] fine_h, fine_w, fine_h2, fine_w2;
  logic [CNT_W-1:0] row0, col0, row1, col1;
  logic [CNT_W:0]   r_inc, c_inc;
  logic [CLW-1:0]   d_ext;
  logic [CNT_W-1:0] d_clamp;
  logic             acc;
  mgfw_pkg::tag_t   tag;

  logic                 dp_wr_en;
  logic [CNT_W-1:0]     dp_wr_addr;
  logic [SW-1:0]        dp_wr_up, dp_wr_mid;
  logic                 m_we;
  logic [CNT_W-1:0]     m_waddr;
  logic [SW-1:0]        m_wup, m_wmid;
  logic [SW-1:0]        rd_top, rd_mid;
  logic                 push;
  logic signed [OW-1:0] push_value;
  mgfw_pkg::tag_t       push_tag;
  mgfw_pkg::pipe_stat_t stat;
  logic [FCW-1:0]       fifo_cnt;
  logic [FCW:0]         occ;
  logic [RES_W-1:0]     res_data;

  assign cfg_ready = 1'b1;

  assign fine_h  = CNT_W'({rows_r, 1'b0} - 1'b1);
  assign fine_w  = CNT_W'({cols_r, 1'b0} - 1'b1);
  assign fine_h2 = fine_h - CNT_W'(2);
  assign fine_w2 = fine_w - CNT_W'(2);

  // clamp register writes to [3, MAX_COARSE]
  assign d_ext = CLW'(cfg_data);
  always_comb begin
    if (d_ext < CLW'(mgfw_pkg::SIZE_MIN)) begin
      d_clamp = CNT_W'(mgfw_pkg::SIZE_MIN);
    end else if (d_ext > CLW'(MAX_COARSE)) begin
      d_clamp = CNT_W'(MAX_COARSE);
    end else begin
      d_clamp = CNT_W'(d_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CNT_W'(mgfw_pkg::SIZE_MIN);
      cols_r <= CNT_W'(mgfw_pkg::SIZE_MIN);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mgfw_pkg::CFG_ROWS: rows_r <= d_clamp;
        mgfw_pkg::CFG_COLS: cols_r <= d_clamp;
        default: ;
      endcase
    end
  end

  assign occ      = {1'b0, fifo_cnt} + (FCW + 1)'(stat.s1_vld) + (FCW + 1)'(stat.s2_vld);
  assign in_ready = !clr_busy_r && (occ < (FCW + 1)'(FD));
  assign acc      = in_valid && in_ready;

  // fine position of this word, then of the next
  always_comb begin
    row0 = in_grid_start ? '0 : row_r;
    col0 = in_grid_start ? '0 : col_r;
    row1 = row0;
    col1 = col0;
    if (col0 >= fine_w) begin
      col1 = '0;
      row1 = row0 + 1'b1;
    end
    if (row1 >= fine_h) begin
      row1 = '0;
    end
    c_inc   = {1'b0, col1} + 1'b1;
    r_inc   = {1'b0, row1} + 1'b1;
    col_nxt = CNT_W'(c_inc);
    row_nxt = row1;
    if (c_inc >= {1'b0, fine_w}) begin
      col_nxt = '0;
      row_nxt = (r_inc >= {1'b0, fine_h}) ? '0 : CNT_W'(r_inc);
    end
  end

  always_comb begin
    tag.emit = (row1 >= CNT_W'(3)) && (col1 >= CNT_W'(3)) && row1[0] && col1[0] &&
               (row1 <= fine_h2) && (col1 <= fine_w2);
    tag.last = (row1 == fine_h2) && (col1 == fine_w2);
    tag.crow = IW'(row1 >> 1);
    tag.ccol = IW'(col1 >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == CNT_W'(LINE_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  assign m_we    = clr_busy_r || dp_wr_en;
  assign m_waddr = clr_busy_r ? clr_addr_r : dp_wr_addr;
  assign m_wup   = clr_busy_r ? '0 : dp_wr_up;
  assign m_wmid  = clr_busy_r ? '0 : dp_wr_mid;

  mgfw_line_mem #(
    .AW(CNT_W),
    .DW(SW)
  ) u_line_mem (
    .clk       (clk),
    .we        (m_we),
    .waddr     (m_waddr),
    .wdata_up  (m_wup),
    .wdata_mid (m_wmid),
    .raddr     (col1),
    .rdata_up  (rd_top),
    .rdata_mid (rd_mid)
  );

  mgfw_datapath #(
    .AW(CNT_W),
    .SW(SW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .x          (in_fine_sample),
    .addr       (col1),
    .tag        (tag),
    .rd_top     (rd_top),
    .rd_mid     (rd_mid),
    .wr_en      (dp_wr_en),
    .wr_addr    (dp_wr_addr),
    .wr_up      (dp_wr_up),
    .wr_mid     (dp_wr_mid),
    .push       (push),
    .push_value (push_value),
    .push_tag   (push_tag),
    .stat       (stat)
  );

  mgfw_out_fifo #(
    .DW   (RES_W),
    .DEPTH(FD)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_value, push_tag.crow, push_tag.ccol, push_tag.last}),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (res_data),
    .count     (fifo_cnt)
  );

  assign out_coarse_value = res_data[RES_W-1 -: OW];
  assign out_coarse_row   = res_data[2*IW : IW+1];
  assign out_coarse_col   = res_data[IW : 1];
  assign out_last_of_grid = res_data[0];

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= (FCW + 1)'(FD))
    else $error("words in flight exceed result queue space");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> col_r < $past(fine_w))
    else $error("column count left the fine grid");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !stat.s1_vld && !stat.s2_vld)
    else $error("word in flight during line buffer sweep");

endmodule

@@ sim/mgfw_restrict_checker.sv @@
`timescale 1ns / 1ps
// Watches the restriction unit's channels, predicts every coarse point and compares.
module mgfw_restrict_checker
  import mgfw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [15:0]      in_fine_sample,
  input  logic                    in_grid_start,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [19:0]      out_coarse_value,
  input  logic [IDX_W-1:0]        out_coarse_row,
  input  logic [IDX_W-1:0]        out_coarse_col,
  input  logic                    out_last_of_grid,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  cfg_reg_t                cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      pending_count,
  output int                      checked_count
);

  localparam int LINE_LEN = 2 * MAX_COARSE_DEF;

  typedef struct {
    logic signed [19:0] value;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               last;
  } coarse_point_t;

  coarse_point_t      coarse_due[$];
  logic signed [15:0] row_up2 [LINE_LEN];
  logic signed [15:0] row_up1 [LINE_LEN];
  logic signed [15:0] win [6];
  int unsigned        row_pos, col_pos, n_rows, n_cols;

  function automatic int unsigned size_of(logic [CFG_W-1:0] v);
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > MAX_COARSE_DEF) return MAX_COARSE_DEF;
    return v;
  endfunction

  task automatic advance_window(logic signed [15:0] x, logic start);
    int unsigned        fh, fw, r, c;
    logic signed [15:0] top, mid;
    int                 acc;
    coarse_point_t      pt;
    fh = 2 * n_rows - 1;
    fw = 2 * n_cols - 1;
    if (start) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= fw) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= fh) row_pos = 0;
    r = row_pos;
    c = col_pos;
    top = row_up2[c];
    mid = row_up1[c];
    if (r >= 3 && c >= 3 && r[0] && c[0] && r <= fh - 2 && c <= fw - 2) begin
      // centre x4, edges x2, corners x1
      acc = 4 * int'(win[3])
          + 2 * (int'(win[1]) + int'(win[2]) + int'(mid) + int'(win[5]))
          + int'(win[0]) + int'(top) + int'(win[4]) + int'(x);
      pt.value = acc[19:0];
      pt.row   = IDX_W'((r - 1) / 2);
      pt.col   = IDX_W'((c - 1) / 2);
      pt.last  = (r == fh - 2) && (c == fw - 2);
      coarse_due.push_back(pt);
    end
    win[0] = win[1];
    win[1] = top;
    win[2] = win[3];
    win[3] = mid;
    win[4] = win[5];
    win[5] = x;
    row_up2[c] = mid;
    row_up1[c] = x;
    col_pos = c + 1;
    if (col_pos >= fw) begin
      col_pos = 0;
      row_pos = (r + 1 >= fh) ? 0 : r + 1;
    end
  endtask

  task automatic match_point();
    coarse_point_t pt;
    if (coarse_due.size() == 0) begin
      $error("unpredicted coarse point: value %0d row %0d col %0d last %0d",
             out_coarse_value, out_coarse_row, out_coarse_col, out_last_of_grid);
      fail_count++;
      return;
    end
    pt = coarse_due.pop_front();
    checked_count++;
    if (out_coarse_value !== pt.value) begin
      $error("coarse_value: expected %0d, actual %0d", pt.value, out_coarse_value);
      fail_count++;
    end
    if (out_coarse_row !== pt.row) begin
      $error("coarse_row: expected %0d, actual %0d", pt.row, out_coarse_row);
      fail_count++;
    end
    if (out_coarse_col !== pt.col) begin
      $error("coarse_col: expected %0d, actual %0d", pt.col, out_coarse_col);
      fail_count++;
    end
    if (out_last_of_grid !== pt.last) begin
      $error("last_of_grid: expected %0d, actual %0d", pt.last, out_last_of_grid);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LINE_LEN; k++) begin
        row_up2[k] = '0;
        row_up1[k] = '0;
      end
      for (int k = 0; k < 6; k++) win[k] = '0;
      row_pos       = 0;
      col_pos       = 0;
      n_rows        = SIZE_MIN;
      n_cols        = SIZE_MIN;
      fail_count    = 0;
      checked_count = 0;
      coarse_due.delete();
    end else begin
      if (out_valid && out_ready) match_point();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROWS) n_rows = size_of(cfg_data);
        else n_cols = size_of(cfg_data);
      end
      if (in_valid && in_ready) advance_window(in_fine_sample, in_grid_start);
    end
    pending_count = coarse_due.size();
  end

endmodule

@@ sim/tb_multigrid_full_weighting_restrict_unit.sv @@
`timescale 1ns / 1ps
// Top of the restriction unit's testbench: clock, reset, stimulus and verdict.
module tb_multigrid_full_weighting_restrict_unit;
  import mgfw_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [15:0]       in_fine_sample;
  logic                     in_grid_start;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [19:0]       out_coarse_value;
  logic [IDX_W-1:0]         out_coarse_row;
  logic [IDX_W-1:0]         out_coarse_col;
  logic                     out_last_of_grid;
  logic                     cfg_valid;
  logic                     cfg_ready;
  cfg_reg_t                 cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  int   fail_count, pending_count, checked_count;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   words_sent = 0;
  int   rows_now = SIZE_MIN;
  int   cols_now = SIZE_MIN;

  multigrid_full_weighting_restrict_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_fine_sample   (in_fine_sample),
    .in_grid_start    (in_grid_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coarse_value (out_coarse_value),
    .out_coarse_row   (out_coarse_row),
    .out_coarse_col   (out_coarse_col),
    .out_last_of_grid (out_last_of_grid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  mgfw_restrict_checker watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_fine_sample   (in_fine_sample),
    .in_grid_start    (in_grid_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coarse_value (out_coarse_value),
    .out_coarse_row   (out_coarse_row),
    .out_coarse_col   (out_coarse_col),
    .out_last_of_grid (out_last_of_grid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("multigrid_full_weighting_restrict_unit verification failed");
    $finish;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(logic signed [15:0] sample, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_fine_sample = sample;
    in_grid_start  = start;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_size(cfg_reg_t idx, logic [CFG_W-1:0] val);
    int sz;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    sz = (val < SIZE_MIN) ? SIZE_MIN : (val > MAX_COARSE_DEF) ? MAX_COARSE_DEF : int'(val);
    if (idx == CFG_ROWS) rows_now = sz;
    else cols_now = sz;
  endtask

  function automatic logic signed [15:0] pick_sample(int mode);
    case (mode)
      1: return 16'sh7fff;
      2: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic feed_grid(int words, logic mark, int mode);
    for (int i = 0; i < words; i++)
      send_word(pick_sample(mode), (i == 0 && mark) || ($urandom_range(199) == 0));
  endtask

  task automatic pick_sizes();
    logic [CFG_W-1:0] rv, cv;
    rv = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(8, 3)) :
                                    CFG_W'($urandom_range(5, 3));
    cv = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(10, 3)) :
                                    CFG_W'($urandom_range(6, 3));
    if ($urandom_range(19) == 0) rv = CFG_W'($urandom_range(2, 0));
    if ($urandom_range(19) == 0) cv = CFG_W'($urandom_range(2, 0));
    set_size(CFG_ROWS, rv);
    set_size(CFG_COLS, cv);
  endtask

  task automatic run_random(int word_goal, int point_goal);
    int words0, pts0, kind, mode, full;
    words0 = words_sent;
    pts0   = checked_count + pending_count;
    while (words_sent - words0 < word_goal ||
           checked_count + pending_count - pts0 < point_goal) begin
      if ($urandom_range(99) < 30) begin
        drain();
        pick_sizes();
      end
      kind = $urandom_range(99);
      mode = $urandom_range(99);
      mode = (mode < 8) ? 1 : (mode < 16) ? 2 : 0;
      full = (2 * rows_now - 1) * (2 * cols_now - 1);
      if (kind < 75) begin
        feed_grid(full, $urandom_range(9) != 0, mode);
      end else if (kind < 85) begin
        feed_grid($urandom_range(full - 1, 1), 1'b1, mode);
      end else if (kind < 95) begin
        // resize in the middle of a grid, then carry on without a start mark
        feed_grid($urandom_range(full - 1, 1), 1'b1, mode);
        drain();
        pick_sizes();
        feed_grid((2 * rows_now - 1) * (2 * cols_now - 1), 1'b0, mode);
      end else begin
        repeat ($urandom_range(10, 1)) send_word(16'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_fine_sample = '0;
    in_grid_start  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_ROWS;
    cfg_data       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: 3x3 coarse grid, full-scale window inside a negative-full-scale frame
    set_size(CFG_ROWS, 10'd3);
    set_size(CFG_COLS, 10'd3);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++)
        send_word((r >= 1 && r <= 3 && c >= 1 && c <= 3) ? 16'sh7fff : 16'sh8000,
                  r == 0 && c == 0);
    drain();

    // fill the result queue behind a long receiver hold-off
    set_size(CFG_COLS, 10'd8);
    hold_req = 1'b1;
    feed_grid(5 * 15, 1'b1, 0);
    drain();

    run_random(50, 4);
    send_idle_pct = 84;
    run_random(50, 4);
    drain();
    send_idle_pct = 0;
    stall_pct     = 84;
    run_random(50, 4);
    drain();
    send_idle_pct = 21;
    stall_pct     = 21;
    run_random(50, 4);
    drain();

    // size extremes, out-of-range writes clamp
    set_size(CFG_COLS, 10'd3);
    set_size(CFG_ROWS, 10'h3ff);
    feed_grid(8 * 5, 1'b1, 0);
    drain();
    set_size(CFG_ROWS, 10'd0);
    set_size(CFG_COLS, 10'd2);
    feed_grid((2 * rows_now - 1) * (2 * cols_now - 1), 1'b1, 0);
    drain();
    set_size(CFG_COLS, 10'd513);
    feed_grid(12, 1'b1, 0);
    drain();

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("multigrid_full_weighting_restrict_unit verification clean");
    end else begin
      $display("multigrid_full_weighting_restrict_unit verification failed");
    end
    $finish;
  end

endmodule
